[design/sca_pkg.sv]
// Shared types, codes and sizes for the send credit admission block.
package sca_pkg;

    localparam int PARK_DEPTH = 16;
    localparam int PTR_W      = $clog2(PARK_DEPTH);
    localparam int CNT_W      = $clog2(PARK_DEPTH + 1);
    localparam int TAG_W      = 16;
    localparam int SLOT_W     = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [SLOT_W-1:0] SLOT_LIMIT_RST      = 16'd128;
    localparam logic [SLOT_W-1:0] READ_SLOT_LIMIT_RST = 16'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SLOT_LIMIT      = 1'b0,
        REG_READ_SLOT_LIMIT = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        KIND_ADMIT   = 2'd0,
        KIND_TRY     = 2'd1,
        KIND_RELEASE = 2'd2,
        KIND_BROKEN  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        EV_DISPATCHED = 3'd0,
        EV_PARKED     = 3'd1,
        EV_FAILED     = 3'd2,
        EV_ACCEPTED   = 3'd3,
        EV_REJECTED   = 3'd4,
        EV_DONE       = 3'd5
    } ev_t;

    typedef enum logic [1:0] {
        FS_NONE     = 2'd0,
        FS_FLUSH    = 2'd1,
        FS_OVERFLOW = 2'd2
    } fs_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_ISSUE,
        S_EMIT
    } state_t;

    typedef struct packed {
        kind_t              kind;
        logic [TAG_W-1:0]   op_tag;
        logic               is_read;
        logic [SLOT_W-1:0]  release_count;
        logic [SLOT_W-1:0]  release_reads;
    } req_t;

    typedef struct packed {
        ev_t                event_res;
        logic [TAG_W-1:0]   op_tag_res;
        logic               op_is_read;
        fs_t                fail_status;
        logic               over_release;
        logic               stalled;
        logic [SLOT_W-1:0]  in_flight;
        logic [SLOT_W-1:0]  reads_in_flight;
        logic               last;
    } res_t;

endpackage

[design/sca_if.sv]
// Request and result channel interfaces with valid/ready handshake.
interface sca_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] op_tag;
    logic        is_read;
    logic [15:0] release_count;
    logic [15:0] release_reads;

    modport source (output valid, kind, op_tag, is_read, release_count, release_reads,
                    input ready);
    modport sink   (input valid, kind, op_tag, is_read, release_count, release_reads,
                    output ready);
endinterface

interface sca_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [15:0] op_tag_res;
    logic        op_is_read;
    logic [1:0]  fail_status;
    logic        over_release;
    logic        stalled;
    logic [15:0] in_flight;
    logic [15:0] reads_in_flight;
    logic        last;

    modport source (output valid, event_res, op_tag_res, op_is_read, fail_status,
                    over_release, stalled, in_flight, reads_in_flight, last,
                    input ready);
    modport sink   (input valid, event_res, op_tag_res, op_is_read, fail_status,
                    over_release, stalled, in_flight, reads_in_flight, last,
                    output ready);
endinterface

[design/send_credit_admission_core.sv]
// Credit admission core: in-flight accounting, parking FIFOs and drain sequencer.
//
// Channels: req (sink) takes one request: admit, try acquire, release or set
// broken. res (source) gives result items, the last one of each request with
// last set. cfg_we/cfg_index/cfg_data write slot_limit (0) and
// read_slot_limit (1); write only while no request is in progress.
// Sequence: a request is taken in idle and executed in the exec state, where
// admit and try acquire give their single result. Release and set broken then
// drain parked entries and finish with the done item; each drained entry costs
// one synchronous read of its parking memory followed by an emit.
// A result sits in an output register; the next request is taken while it
// waits. When res stalls, the sequencer holds until the register frees.
// Reset: counts clear, limits return to 128 and 16, both parking FIFOs
// become empty and the broken flag clears. Parking memories are not cleared.
module send_credit_admission_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    sca_req_if.sink                               req,
    sca_res_if.source                             res,
    input  logic                                  cfg_we,
    input  logic [sca_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [sca_pkg::SLOT_W-1:0]            cfg_data
);

    sca_pkg::state_t                 state_reg, state_next;
    sca_pkg::req_t                   req_reg;
    sca_pkg::res_t                   out_reg, out_next;
    logic                            out_valid_reg, out_valid_next;

    logic [sca_pkg::SLOT_W-1:0]      limit_reg, rlimit_reg;
    logic [sca_pkg::SLOT_W-1:0]      flight_reg, flight_next;
    logic [sca_pkg::SLOT_W-1:0]      rflight_reg, rflight_next;
    logic                            broken_reg, broken_next;
    logic                            over_reg, over_next;
    logic                            sel_rd_reg, sel_rd_next;

    logic [sca_pkg::PTR_W-1:0]       rhead_reg, rhead_next, rtail_reg, rtail_next;
    logic [sca_pkg::PTR_W-1:0]       whead_reg, whead_next, wtail_reg, wtail_next;
    logic [sca_pkg::CNT_W-1:0]       rcnt_reg, rcnt_next, wcnt_reg, wcnt_next;

    logic [sca_pkg::TAG_W-1:0]       rmem [sca_pkg::PARK_DEPTH];
    logic [sca_pkg::TAG_W-1:0]       wmem [sca_pkg::PARK_DEPTH];
    logic [sca_pkg::TAG_W-1:0]       rq_reg, wq_reg;
    logic                            rpush, wpush;

    logic                            can_emit;
    logic                            full_blk, rd_blk, flush_mode;
    logic                            pick_rd, pick_wr;
    logic [sca_pkg::SLOT_W-1:0]      rel_clamp, relrd_clamp;

    function automatic logic [sca_pkg::PTR_W-1:0] ptr_inc(
        input logic [sca_pkg::PTR_W-1:0] p);
        if (p == sca_pkg::PTR_W'(sca_pkg::PARK_DEPTH - 1))
            return '0;
        return p + 1'b1;
    endfunction

    assign can_emit   = !out_valid_reg || res.ready;
    assign full_blk   = flight_reg >= limit_reg;
    assign rd_blk     = full_blk || (rflight_reg >= rlimit_reg);
    assign flush_mode = req_reg.kind == sca_pkg::KIND_BROKEN;
    assign pick_rd    = (rcnt_reg != '0) && (flush_mode || (!broken_reg && !rd_blk));
    assign pick_wr    = !pick_rd && (wcnt_reg != '0)
                        && (flush_mode || (!broken_reg && !full_blk));
    assign rel_clamp   = (req_reg.release_count > flight_reg) ? flight_reg
                                                               : req_reg.release_count;
    assign relrd_clamp = (req_reg.release_reads < rflight_reg) ? req_reg.release_reads
                                                               : rflight_reg;

    assign req.ready = state_reg == sca_pkg::S_IDLE;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sca_pkg::S_IDLE:
            begin
                if (req.valid)
                    state_next = sca_pkg::S_EXEC;
            end
            sca_pkg::S_EXEC:
            begin
                if (req_reg.kind == sca_pkg::KIND_RELEASE
                    || req_reg.kind == sca_pkg::KIND_BROKEN)
                    state_next = sca_pkg::S_ISSUE;
                else if (can_emit)
                    state_next = sca_pkg::S_IDLE;
            end
            sca_pkg::S_ISSUE:
            begin
                if (pick_rd || pick_wr)
                    state_next = sca_pkg::S_EMIT;
                else if (can_emit)
                    state_next = sca_pkg::S_IDLE;
            end
            sca_pkg::S_EMIT:
            begin
                if (can_emit)
                    state_next = sca_pkg::S_ISSUE;
            end
            default: state_next = sca_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !res.ready;
        flight_next    = flight_reg;
        rflight_next   = rflight_reg;
        broken_next    = broken_reg;
        over_next      = over_reg;
        sel_rd_next    = sel_rd_reg;
        rhead_next     = rhead_reg;
        rtail_next     = rtail_reg;
        whead_next     = whead_reg;
        wtail_next     = wtail_reg;
        rcnt_next      = rcnt_reg;
        wcnt_next      = wcnt_reg;
        rpush          = 1'b0;
        wpush          = 1'b0;
        case (state_reg)
            sca_pkg::S_IDLE:
            begin
            end
            sca_pkg::S_EXEC:
            begin
                case (req_reg.kind)
                    sca_pkg::KIND_RELEASE:
                    begin
                        over_next    = req_reg.release_count > flight_reg;
                        flight_next  = flight_reg - rel_clamp;
                        rflight_next = rflight_reg - relrd_clamp;
                    end
                    sca_pkg::KIND_BROKEN:
                    begin
                        broken_next = 1'b1;
                        over_next   = 1'b0;
                    end
                    default:
                    begin
                        if (can_emit)
                        begin
                            out_next.op_tag_res   = req_reg.op_tag;
                            out_next.op_is_read   = req_reg.is_read;
                            out_next.fail_status  = sca_pkg::FS_NONE;
                            out_next.over_release = 1'b0;
                            out_next.stalled      = 1'b0;
                            out_next.last         = 1'b1;
                            if (req_reg.kind == sca_pkg::KIND_TRY)
                            begin
                                if (broken_reg || (req_reg.is_read ? rd_blk : full_blk))
                                    out_next.event_res = sca_pkg::EV_REJECTED;
                                else
                                begin
                                    out_next.event_res = sca_pkg::EV_ACCEPTED;
                                    flight_next = flight_reg + 1'b1;
                                    if (req_reg.is_read)
                                        rflight_next = rflight_reg + 1'b1;
                                end
                            end
                            else if (broken_reg)
                            begin
                                out_next.event_res   = sca_pkg::EV_FAILED;
                                out_next.fail_status = sca_pkg::FS_FLUSH;
                            end
                            else if (req_reg.is_read && rd_blk)
                            begin
                                if (rcnt_reg == sca_pkg::CNT_W'(sca_pkg::PARK_DEPTH))
                                begin
                                    out_next.event_res   = sca_pkg::EV_FAILED;
                                    out_next.fail_status = sca_pkg::FS_OVERFLOW;
                                end
                                else
                                begin
                                    out_next.event_res = sca_pkg::EV_PARKED;
                                    rpush      = 1'b1;
                                    rtail_next = ptr_inc(rtail_reg);
                                    rcnt_next  = rcnt_reg + 1'b1;
                                end
                            end
                            else if (!req_reg.is_read && full_blk)
                            begin
                                if (wcnt_reg == sca_pkg::CNT_W'(sca_pkg::PARK_DEPTH))
                                begin
                                    out_next.event_res   = sca_pkg::EV_FAILED;
                                    out_next.fail_status = sca_pkg::FS_OVERFLOW;
                                end
                                else
                                begin
                                    out_next.event_res = sca_pkg::EV_PARKED;
                                    wpush      = 1'b1;
                                    wtail_next = ptr_inc(wtail_reg);
                                    wcnt_next  = wcnt_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                out_next.event_res = sca_pkg::EV_DISPATCHED;
                                flight_next = flight_reg + 1'b1;
                                if (req_reg.is_read)
                                    rflight_next = rflight_reg + 1'b1;
                            end
                            out_next.in_flight       = flight_next;
                            out_next.reads_in_flight = rflight_next;
                            out_valid_next           = 1'b1;
                        end
                    end
                endcase
            end
            sca_pkg::S_ISSUE:
            begin
                sel_rd_next = pick_rd;
                if (!pick_rd && !pick_wr && can_emit)
                begin
                    out_next.event_res       = sca_pkg::EV_DONE;
                    out_next.op_tag_res      = '0;
                    out_next.op_is_read      = 1'b0;
                    out_next.fail_status     = sca_pkg::FS_NONE;
                    out_next.over_release    = over_reg;
                    out_next.stalled         = !broken_reg && (flight_reg == '0)
                                               && ((rcnt_reg != '0) || (wcnt_reg != '0));
                    out_next.in_flight       = flight_reg;
                    out_next.reads_in_flight = rflight_reg;
                    out_next.last            = 1'b1;
                    out_valid_next           = 1'b1;
                end
            end
            sca_pkg::S_EMIT:
            begin
                if (can_emit)
                begin
                    out_next.op_tag_res   = sel_rd_reg ? rq_reg : wq_reg;
                    out_next.op_is_read   = sel_rd_reg;
                    out_next.over_release = 1'b0;
                    out_next.stalled      = 1'b0;
                    out_next.last         = 1'b0;
                    if (flush_mode)
                    begin
                        out_next.event_res   = sca_pkg::EV_FAILED;
                        out_next.fail_status = sca_pkg::FS_FLUSH;
                    end
                    else
                    begin
                        out_next.event_res   = sca_pkg::EV_DISPATCHED;
                        out_next.fail_status = sca_pkg::FS_NONE;
                        flight_next = flight_reg + 1'b1;
                        if (sel_rd_reg)
                            rflight_next = rflight_reg + 1'b1;
                    end
                    if (sel_rd_reg)
                    begin
                        rhead_next = ptr_inc(rhead_reg);
                        rcnt_next  = rcnt_reg - 1'b1;
                    end
                    else
                    begin
                        whead_next = ptr_inc(whead_reg);
                        wcnt_next  = wcnt_reg - 1'b1;
                    end
                    out_next.in_flight       = flight_next;
                    out_next.reads_in_flight = rflight_next;
                    out_valid_next           = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sca_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            limit_reg     <= sca_pkg::SLOT_LIMIT_RST;
            rlimit_reg    <= sca_pkg::READ_SLOT_LIMIT_RST;
            flight_reg    <= '0;
            rflight_reg   <= '0;
            broken_reg    <= 1'b0;
            rhead_reg     <= '0;
            rtail_reg     <= '0;
            whead_reg     <= '0;
            wtail_reg     <= '0;
            rcnt_reg      <= '0;
            wcnt_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            flight_reg    <= flight_next;
            rflight_reg   <= rflight_next;
            broken_reg    <= broken_next;
            rhead_reg     <= rhead_next;
            rtail_reg     <= rtail_next;
            whead_reg     <= whead_next;
            wtail_reg     <= wtail_next;
            rcnt_reg      <= rcnt_next;
            wcnt_reg      <= wcnt_next;
            if (cfg_we && cfg_index == sca_pkg::REG_SLOT_LIMIT)
                limit_reg <= cfg_data;
            if (cfg_we && cfg_index == sca_pkg::REG_READ_SLOT_LIMIT)
                rlimit_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg    <= out_next;
        over_reg   <= over_next;
        sel_rd_reg <= sel_rd_next;
        if (req.valid && req.ready)
        begin
            req_reg.kind          <= sca_pkg::kind_t'(req.kind);
            req_reg.op_tag        <= req.op_tag;
            req_reg.is_read       <= req.is_read;
            req_reg.release_count <= req.release_count;
            req_reg.release_reads <= req.release_reads;
        end
    end

    // parking memories, head entry read into a register ahead of the emit
    always_ff @(posedge clk)
    begin
        if (rpush)
            rmem[rtail_reg] <= req_reg.op_tag;
        rq_reg <= rmem[rhead_reg];
    end

    always_ff @(posedge clk)
    begin
        if (wpush)
            wmem[wtail_reg] <= req_reg.op_tag;
        wq_reg <= wmem[whead_reg];
    end

    assign res.valid           = out_valid_reg;
    assign res.event_res       = out_reg.event_res;
    assign res.op_tag_res      = out_reg.op_tag_res;
    assign res.op_is_read      = out_reg.op_is_read;
    assign res.fail_status     = out_reg.fail_status;
    assign res.over_release    = out_reg.over_release;
    assign res.stalled         = out_reg.stalled;
    assign res.in_flight       = out_reg.in_flight;
    assign res.reads_in_flight = out_reg.reads_in_flight;
    assign res.last            = out_reg.last;

endmodule

[design/sca_checker.sv]
// Port-level checks for the credit admission core, bound to the core module.
module sca_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [2:0]  res_event,
    input logic [1:0]  res_fail,
    input logic        res_over,
    input logic        res_last
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous one in progress");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_event == sca_pkg::EV_DONE |-> res_last)
        else $error("done result without last");

    a_over_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_over |-> res_event == sca_pkg::EV_DONE)
        else $error("over_release outside done result");

    a_fail_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_fail != sca_pkg::FS_NONE |-> res_event == sca_pkg::EV_FAILED)
        else $error("fail status on non-failed result");

endmodule

bind send_credit_admission_core sca_checker u_sca_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_event (res.event_res),
    .res_fail  (res.fail_status),
    .res_over  (res.over_release),
    .res_last  (res.last)
);
